// ----- rtl/mre_pkg.sv -----
// ----------------------------------------------------------------------------
// mre_pkg
// Shared types, function codes and the instruction decoder for the
// SPECIAL-opcode execute block.
// ----------------------------------------------------------------------------
package mre_pkg;

    localparam int          C_NUM_REGS  = 32;
    localparam logic [31:0] C_RESET_PC  = 32'h0040_0000;
    localparam logic [31:0] C_PC_STEP   = 32'd4;
    localparam logic [31:0] C_EXIT_CODE = 32'h0000_000A;
    localparam logic [4:0]  C_SYS_REG   = 5'd2;

    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;

    typedef enum logic [3:0] {
        CL_ALU,
        CL_JR,
        CL_SYS,
        CL_MFHI,
        CL_MFLO,
        CL_MTHI,
        CL_MTLO,
        CL_MUL,
        CL_DIV,
        CL_ILL
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic [5:0] fn;
        logic       sgn;
        logic [4:0] rs;
        logic [4:0] rt;
        logic [4:0] rd;
        logic [4:0] sh;
    } t_dec;

    typedef struct packed {
        logic valid;
        t_dec dec;
    } t_head;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MUL,
        S_MULFIX,
        S_DIV,
        S_DIVFIX
    } t_state;

    function automatic t_dec decode(input logic [31:0] w);
        t_dec d;
        d.fn  = w[5:0];
        d.rs  = w[25:21];
        d.rt  = w[20:16];
        d.rd  = w[15:11];
        d.sh  = w[10:6];
        d.sgn = 1'b0;
        d.cls = CL_ILL;
        case (w[5:0])
            FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
            FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
            FN_XOR, FN_NOR, FN_SLT: d.cls = CL_ALU;
            FN_JR: d.cls = CL_JR;
            FN_SYSCALL: begin
                d.cls = CL_SYS;
                d.rs  = C_SYS_REG;
            end
            FN_MFHI: d.cls = CL_MFHI;
            FN_MFLO: d.cls = CL_MFLO;
            FN_MTHI: d.cls = CL_MTHI;
            FN_MTLO: d.cls = CL_MTLO;
            FN_MULT: begin
                d.cls = CL_MUL;
                d.sgn = 1'b1;
            end
            FN_MULTU: d.cls = CL_MUL;
            FN_DIV: begin
                d.cls = CL_DIV;
                d.sgn = 1'b1;
            end
            FN_DIVU: d.cls = CL_DIV;
            default: d.cls = CL_ILL;
        endcase
        return d;
    endfunction

endpackage

// ----- rtl/mre_ram.sv -----
// ----------------------------------------------------------------------------
// mre_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module mre_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

// ----- rtl/mre_front.sv -----
// ----------------------------------------------------------------------------
// mre_front
// Accepts instruction words, decodes them and holds them in a two-entry
// queue for the execute stage.
// ----------------------------------------------------------------------------
module mre_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic [31:0]   i_instr_word,
    output logic          o_full,
    input  logic          i_take,
    output mre_pkg::t_head o_head
);
    import mre_pkg::*;

    t_dec       r_q [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_cnt;
    logic       w_push;
    logic       w_take;

    assign o_full       = (r_cnt == 2'd2);
    assign w_push       = i_push && !o_full;
    assign w_take       = i_take && (r_cnt != 2'd0);
    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.dec   = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wptr] <= decode(i_instr_word);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_take) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_take};
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3)
        else $error("front queue count out of range");
    a_no_take_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !w_push) |=> (r_cnt == 2'd0))
        else $error("front queue count moved without a transaction");
endmodule

// ----- rtl/mre_exec.sv -----
// ----------------------------------------------------------------------------
// mre_exec
// Execute stage: register file, HI/LO, program counter, iterative divider,
// registered multiplier and the result register.
// ----------------------------------------------------------------------------
module mre_exec #(
    parameter int NUM_REGS = mre_pkg::C_NUM_REGS
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_reset_pc_we,
    input  logic [31:0]    i_reset_pc,
    input  mre_pkg::t_head i_head,
    output logic           o_take,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [31:0]    o_next_pc,
    output logic           o_reg_written,
    output logic [4:0]     o_dest_index,
    output logic [31:0]    o_dest_value,
    output logic [31:0]    o_hi_value,
    output logic [31:0]    o_lo_value,
    output logic           o_halt,
    output logic           o_illegal
);
    import mre_pkg::*;

    localparam int IW = $clog2(NUM_REGS);

    t_state        r_state, n_state;
    t_dec          r_dec, n_dec;
    logic [31:0]   r_reset_pc;
    logic [31:0]   r_pc, n_pc;
    logic [31:0]   r_hi, n_hi;
    logic [31:0]   r_lo, n_lo;
    logic          r_stopped, n_stopped;
    logic [NUM_REGS-1:0] r_vld;
    logic          r_va, r_vb;
    logic [31:0]   r_ma, n_ma;
    logic [31:0]   r_mb, n_mb;
    logic          r_qneg, n_qneg;
    logic          r_rneg, n_rneg;
    logic [63:0]   r_prod, n_prod;
    logic [31:0]   r_rem, n_rem;
    logic [31:0]   r_quo, n_quo;
    logic [4:0]    r_cnt, n_cnt;
    logic          r_full, n_full;
    logic [31:0]   r_o_npc, n_o_npc;
    logic          r_o_wr, n_o_wr;
    logic [4:0]    r_o_idx, n_o_idx;
    logic [31:0]   r_o_val, n_o_val;
    logic          r_o_halt, n_o_halt;
    logic          r_o_ill, n_o_ill;

    logic          w_we;
    logic [31:0]   w_wdata;
    logic [31:0]   w_rda, w_rdb;
    logic [31:0]   w_a, w_b;
    logic [31:0]   w_val;
    logic [4:0]    w_amt;
    logic          w_wr;
    logic [32:0]   w_rsh;
    logic [32:0]   w_diff;
    logic          w_ge;
    logic          w_pop;

    mre_ram #(
        .WIDTH(32),
        .DEPTH(NUM_REGS)
    ) u_regs (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (IW'(r_dec.rd)),
        .i_wdata   (w_wdata),
        .i_raddr_a (IW'(i_head.dec.rs)),
        .i_raddr_b (IW'(i_head.dec.rt)),
        .o_rdata_a (w_rda),
        .o_rdata_b (w_rdb)
    );

    assign w_pop   = i_pop && r_full;
    assign w_a     = r_va ? w_rda : 32'd0;
    assign w_b     = r_vb ? w_rdb : 32'd0;
    assign w_amt   = (r_dec.fn == FN_SLLV || r_dec.fn == FN_SRLV || r_dec.fn == FN_SRAV)
                     ? w_a[4:0] : r_dec.sh;
    assign w_rsh   = {r_rem, r_quo[31]};
    assign w_diff  = w_rsh - {1'b0, r_mb};
    assign w_ge    = !w_diff[32];
    assign o_empty = !r_full;
    assign o_next_pc     = r_o_npc;
    assign o_reg_written = r_o_wr;
    assign o_dest_index  = r_o_idx;
    assign o_dest_value  = r_o_val;
    assign o_hi_value    = r_hi;
    assign o_lo_value    = r_lo;
    assign o_halt        = r_o_halt;
    assign o_illegal     = r_o_ill;

    always_comb begin
        case (r_dec.fn)
            FN_SLL, FN_SLLV: w_val = w_b << w_amt;
            FN_SRL, FN_SRLV: w_val = w_b >> w_amt;
            FN_SRA, FN_SRAV: w_val = 32'($signed(w_b) >>> w_amt);
            FN_ADD, FN_ADDU: w_val = w_a + w_b;
            FN_SUB, FN_SUBU: w_val = w_a - w_b;
            FN_AND:          w_val = w_a & w_b;
            FN_OR:           w_val = w_a | w_b;
            FN_XOR:          w_val = w_a ^ w_b;
            FN_NOR:          w_val = ~(w_a | w_b);
            FN_SLT:          w_val = {31'd0, $signed(w_a) < $signed(w_b)};
            default:         w_val = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_reset_pc <= C_RESET_PC;
            r_pc       <= C_RESET_PC;
            r_hi       <= 32'd0;
            r_lo       <= 32'd0;
            r_stopped  <= 1'b0;
            r_vld      <= '0;
            r_full     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pc      <= n_pc;
            r_hi      <= n_hi;
            r_lo      <= n_lo;
            r_stopped <= n_stopped;
            r_full    <= n_full;
            if (i_reset_pc_we) begin
                r_reset_pc <= i_reset_pc;
            end
            if (w_we) begin
                r_vld[IW'(r_dec.rd)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec    <= n_dec;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_qneg   <= n_qneg;
        r_rneg   <= n_rneg;
        r_prod   <= n_prod;
        r_rem    <= n_rem;
        r_quo    <= n_quo;
        r_cnt    <= n_cnt;
        r_o_npc  <= n_o_npc;
        r_o_wr   <= n_o_wr;
        r_o_idx  <= n_o_idx;
        r_o_val  <= n_o_val;
        r_o_halt <= n_o_halt;
        r_o_ill  <= n_o_ill;
        r_va     <= (i_head.dec.rs != 5'd0) && r_vld[IW'(i_head.dec.rs)];
        r_vb     <= (i_head.dec.rt != 5'd0) && r_vld[IW'(i_head.dec.rt)];
    end

    always_comb begin
        n_state   = r_state;
        n_dec     = r_dec;
        n_pc      = r_pc;
        n_hi      = r_hi;
        n_lo      = r_lo;
        n_stopped = r_stopped;
        n_ma      = r_ma;
        n_mb      = r_mb;
        n_qneg    = r_qneg;
        n_rneg    = r_rneg;
        n_prod    = r_prod;
        n_rem     = r_rem;
        n_quo     = r_quo;
        n_cnt     = r_cnt;
        n_full    = w_pop ? 1'b0 : r_full;
        n_o_npc   = r_o_npc;
        n_o_wr    = r_o_wr;
        n_o_idx   = r_o_idx;
        n_o_val   = r_o_val;
        n_o_halt  = r_o_halt;
        n_o_ill   = r_o_ill;
        o_take    = 1'b0;
        w_we      = 1'b0;
        w_wdata   = w_val;
        w_wr      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_head.valid && !r_full) begin
                    o_take  = 1'b1;
                    n_dec   = i_head.dec;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state  = S_IDLE;
                n_o_npc  = r_pc + C_PC_STEP;
                n_o_halt = r_stopped;
                n_o_ill  = 1'b0;
                n_full   = 1'b1;
                if (r_stopped) begin
                    n_o_npc = r_pc;
                end else begin
                    case (r_dec.cls)
                        CL_ALU:  w_wr = 1'b1;
                        CL_MFHI: begin
                            w_wr    = 1'b1;
                            w_wdata = r_hi;
                        end
                        CL_MFLO: begin
                            w_wr    = 1'b1;
                            w_wdata = r_lo;
                        end
                        CL_JR:   n_o_npc = w_a;
                        CL_SYS: begin
                            if (w_a == C_EXIT_CODE) begin
                                n_stopped = 1'b1;
                                n_o_halt  = 1'b1;
                                n_o_npc   = r_pc;
                            end
                        end
                        CL_MTHI: n_hi = w_a;
                        CL_MTLO: n_lo = w_a;
                        CL_MUL: begin
                            n_ma    = (r_dec.sgn && w_a[31]) ? -w_a : w_a;
                            n_mb    = (r_dec.sgn && w_b[31]) ? -w_b : w_b;
                            n_qneg  = r_dec.sgn && (w_a[31] ^ w_b[31]);
                            n_full  = r_full;
                            n_state = S_MUL;
                        end
                        CL_DIV: begin
                            if (w_b != 32'd0) begin
                                n_mb    = (r_dec.sgn && w_b[31]) ? -w_b : w_b;
                                n_quo   = (r_dec.sgn && w_a[31]) ? -w_a : w_a;
                                n_rem   = 32'd0;
                                n_cnt   = 5'd0;
                                n_qneg  = r_dec.sgn && (w_a[31] ^ w_b[31]);
                                n_rneg  = r_dec.sgn && w_a[31];
                                n_full  = r_full;
                                n_state = S_DIV;
                            end
                        end
                        CL_ILL: begin
                            n_o_ill = 1'b1;
                            n_o_npc = r_pc;
                        end
                        default: begin
                            n_o_ill = 1'b1;
                            n_o_npc = r_pc;
                        end
                    endcase
                end
                w_we    = w_wr && (r_dec.rd != 5'd0);
                n_o_wr  = w_we;
                n_o_idx = w_we ? r_dec.rd : 5'd0;
                n_o_val = w_we ? w_wdata : 32'd0;
                if (n_state == S_IDLE) begin
                    n_pc = n_o_npc;
                end
            end
            S_MUL: begin
                n_prod  = r_ma * r_mb;
                n_state = S_MULFIX;
            end
            S_MULFIX: begin
                {n_hi, n_lo} = r_qneg ? -r_prod : r_prod;
                n_pc    = r_pc + C_PC_STEP;
                n_full  = 1'b1;
                n_state = S_IDLE;
            end
            S_DIV: begin
                n_rem = w_ge ? w_diff[31:0] : w_rsh[31:0];
                n_quo = {r_quo[30:0], w_ge};
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    n_state = S_DIVFIX;
                end
            end
            S_DIVFIX: begin
                n_lo    = r_qneg ? -r_quo : r_quo;
                n_hi    = r_rneg ? -r_rem : r_rem;
                n_pc    = r_pc + C_PC_STEP;
                n_full  = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    a_reset_pc: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (r_pc == r_reset_pc))
        else $error("program counter does not hold the reset value after reset");
    a_no_r0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_dec.rd != 5'd0))
        else $error("register zero written");
    a_stop_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped)
        else $error("stopped flag cleared without reset");
    a_take_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_take |-> (!r_full && r_state == S_IDLE))
        else $error("instruction taken while a result is pending");
endmodule

// ----- rtl/mips_rtype_execute_top.sv -----
// ----------------------------------------------------------------------------
// mips_rtype_execute_top
// Executes MIPS SPECIAL instruction words against a register file, HI, LO
// and the program counter.
//
// Channel   Direction  Handshake          Payload
// input     in         i_push / o_full    i_instr_word
// result    out        i_pop / o_empty    o_next_pc .. o_illegal
// config    in         i_reset_pc_we      i_reset_pc
//
// A transaction passes S_EXEC after the take; on a running machine a multiply also
// passes S_MUL and S_MULFIX, and a divide by a nonzero divisor S_DIV and S_DIVFIX.
// The divider retires one quotient bit per cycle.
// Reset is synchronous and clears the register file valid bits at once.
// A new instruction is taken only in a cycle that starts with the result register
// empty; up to two decoded instructions wait in the front queue meanwhile.
// ----------------------------------------------------------------------------
module mips_rtype_execute_top #(
    parameter int NUM_REGS = mre_pkg::C_NUM_REGS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_reset_pc_we,
    input  logic [31:0] i_reset_pc,
    input  logic        i_push,
    input  logic [31:0] i_instr_word,
    output logic        o_full,
    input  logic        i_pop,
    output logic        o_empty,
    output logic [31:0] o_next_pc,
    output logic        o_reg_written,
    output logic [4:0]  o_dest_index,
    output logic [31:0] o_dest_value,
    output logic [31:0] o_hi_value,
    output logic [31:0] o_lo_value,
    output logic        o_halt,
    output logic        o_illegal
);
    import mre_pkg::*;

    t_head w_head;
    logic  w_take;

    mre_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .i_instr_word (i_instr_word),
        .o_full       (o_full),
        .i_take       (w_take),
        .o_head       (w_head)
    );

    mre_exec #(
        .NUM_REGS(NUM_REGS)
    ) u_exec (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_reset_pc_we (i_reset_pc_we),
        .i_reset_pc    (i_reset_pc),
        .i_head        (w_head),
        .o_take        (w_take),
        .i_pop         (i_pop),
        .o_empty       (o_empty),
        .o_next_pc     (o_next_pc),
        .o_reg_written (o_reg_written),
        .o_dest_index  (o_dest_index),
        .o_dest_value  (o_dest_value),
        .o_hi_value    (o_hi_value),
        .o_lo_value    (o_lo_value),
        .o_halt        (o_halt),
        .o_illegal     (o_illegal)
    );
endmodule

// ----- sim/mips_rtype_execute_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mips_rtype_execute_top_tb
// Self-checking bench for the SPECIAL-opcode execute block. Instruction words
// go in through the push side. A predictor with its own register file, HI, LO
// and program counter computes each result. Every popped transaction is
// checked field by field against the oldest predicted one. Random gaps,
// a long stall on the result side and writes of the reset PC register run
// between phases.
// ----------------------------------------------------------------------------
module mips_rtype_execute_top_tb;
    import mre_pkg::*;

    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL_WAIT  = 40;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  dest_index;
        logic [31:0] dest_value;
        logic [31:0] hi_value;
        logic [31:0] lo_value;
        logic        halt;
        logic        illegal;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_reset_pc_we;
    logic [31:0] i_reset_pc;
    logic        i_push;
    logic [31:0] i_instr_word;
    logic        o_full;
    logic        i_pop;
    logic        o_empty;
    logic [31:0] o_next_pc;
    logic        o_reg_written;
    logic [4:0]  o_dest_index;
    logic [31:0] o_dest_value;
    logic [31:0] o_hi_value;
    logic [31:0] o_lo_value;
    logic        o_halt;
    logic        o_illegal;

    logic [31:0] gpr [C_NUM_REGS];
    logic [31:0] hi_q;
    logic [31:0] lo_q;
    logic [31:0] pc_q;
    logic        stopped_q;
    logic [31:0] reset_pc_q;

    t_res expected_q[$];
    int   n_sent;
    int   n_checked;
    int   n_errors;
    int   idle_cycles;
    int   hold_request;
    int   hold_left;
    int   pop_stall;
    bit   tx_steady;
    bit   rx_steady;

    logic [5:0] valid_fns [25] = '{
        FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV, FN_JR, FN_SYSCALL,
        FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT, FN_MULTU, FN_DIV, FN_DIVU,
        FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR, FN_XOR, FN_NOR, FN_SLT
    };

    mips_rtype_execute_top uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_reset_pc_we(i_reset_pc_we),
        .i_reset_pc(i_reset_pc),
        .i_push(i_push),
        .i_instr_word(i_instr_word),
        .o_full(o_full),
        .i_pop(i_pop),
        .o_empty(o_empty),
        .o_next_pc(o_next_pc),
        .o_reg_written(o_reg_written),
        .o_dest_index(o_dest_index),
        .o_dest_value(o_dest_value),
        .o_hi_value(o_hi_value),
        .o_lo_value(o_lo_value),
        .o_halt(o_halt),
        .o_illegal(o_illegal)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic logic [31:0] rtype(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sh);
        return {6'b0, rs, rt, rd, sh, fn};
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic logic [31:0] gpr_read(logic [4:0] idx);
        return (idx == 5'd0) ? 32'd0 : gpr[idx];
    endfunction

    function automatic t_res execute_instr(logic [31:0] w);
        t_res        r;
        logic [5:0]  fn;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] val;
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] rm;
        logic [63:0] prod;
        logic        wr;
        fn  = w[5:0];
        rd  = w[15:11];
        sh  = w[10:6];
        a   = gpr_read(w[25:21]);
        b   = gpr_read(w[20:16]);
        r   = '0;
        wr  = 1'b0;
        val = '0;
        r.next_pc = pc_q + C_PC_STEP;
        if (stopped_q) begin
            r.next_pc = pc_q;
            r.halt = 1'b1;
        end else begin
            case (fn)
                FN_SLL:  begin wr = 1'b1; val = b << sh; end
                FN_SRL:  begin wr = 1'b1; val = b >> sh; end
                FN_SRA:  begin wr = 1'b1; val = $signed(b) >>> sh; end
                FN_SLLV: begin wr = 1'b1; val = b << a[4:0]; end
                FN_SRLV: begin wr = 1'b1; val = b >> a[4:0]; end
                FN_SRAV: begin wr = 1'b1; val = $signed(b) >>> a[4:0]; end
                FN_JR:   r.next_pc = a;
                FN_SYSCALL: begin
                    if (gpr_read(C_SYS_REG) == C_EXIT_CODE) begin
                        stopped_q = 1'b1;
                        r.halt = 1'b1;
                        r.next_pc = pc_q;
                    end
                end
                FN_MFHI: begin wr = 1'b1; val = hi_q; end
                FN_MTHI: hi_q = a;
                FN_MFLO: begin wr = 1'b1; val = lo_q; end
                FN_MTLO: lo_q = a;
                FN_MULT, FN_MULTU: begin
                    if (fn == FN_MULT) prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                    else prod = {32'd0, a} * {32'd0, b};
                    hi_q = prod[63:32];
                    lo_q = prod[31:0];
                end
                FN_DIV: begin
                    if (b != 0) begin
                        ma = a[31] ? -a : a;
                        mb = b[31] ? -b : b;
                        q  = ma / mb;
                        rm = ma % mb;
                        lo_q = (a[31] != b[31]) ? -q : q;
                        hi_q = a[31] ? -rm : rm;
                    end
                end
                FN_DIVU: begin
                    if (b != 0) begin
                        lo_q = a / b;
                        hi_q = a % b;
                    end
                end
                FN_ADD, FN_ADDU: begin wr = 1'b1; val = a + b; end
                FN_SUB, FN_SUBU: begin wr = 1'b1; val = a - b; end
                FN_AND:  begin wr = 1'b1; val = a & b; end
                FN_OR:   begin wr = 1'b1; val = a | b; end
                FN_XOR:  begin wr = 1'b1; val = a ^ b; end
                FN_NOR:  begin wr = 1'b1; val = ~(a | b); end
                FN_SLT:  begin wr = 1'b1; val = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0; end
                default: begin
                    r.illegal = 1'b1;
                    r.next_pc = pc_q;
                end
            endcase
            if (rd == 5'd0) wr = 1'b0;
            if (wr) gpr[rd] = val;
            pc_q = r.next_pc;
        end
        r.reg_written = wr;
        r.dest_index  = wr ? rd : 5'd0;
        r.dest_value  = wr ? val : 32'd0;
        r.hi_value    = hi_q;
        r.lo_value    = lo_q;
        return r;
    endfunction

    function automatic int check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        t_res e;
        int   bad;
        logic nxt;
        if (i_rst_n && i_pop && !o_empty) begin
            n_checked++;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transaction, next_pc %h", $time, o_next_pc);
                n_errors++;
            end else begin
                e = expected_q.pop_front();
                bad = check_field("next_pc", e.next_pc, o_next_pc)
                    + check_field("reg_written", 32'(e.reg_written), 32'(o_reg_written))
                    + check_field("dest_index", 32'(e.dest_index), 32'(o_dest_index))
                    + check_field("dest_value", e.dest_value, o_dest_value)
                    + check_field("hi_value", e.hi_value, o_hi_value)
                    + check_field("lo_value", e.lo_value, o_lo_value)
                    + check_field("halt", 32'(e.halt), 32'(o_halt))
                    + check_field("illegal", 32'(e.illegal), 32'(o_illegal));
                if (bad != 0) n_errors++;
            end
        end
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            nxt = 1'b0;
        end else if (rx_steady) begin
            nxt = 1'b1;
        end else if (pop_stall > 0) begin
            pop_stall--;
            nxt = 1'b0;
        end else begin
            pop_stall = pick_gap();
            nxt = (pop_stall == 0);
        end
        i_pop <= nxt;
    end

    always @(posedge i_clk) begin
        if ((i_push && !o_full) || (i_pop && !o_empty)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("%0t: timeout with %0d transactions outstanding", $time,
                     expected_q.size());
            $display("mips_rtype_execute_top_tb: FAIL");
            $finish;
        end
    end

    task automatic send_instr(logic [31:0] w);
        int gap;
        i_push <= 1'b1;
        i_instr_word <= w;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        expected_q.push_back(execute_instr(w));
        n_sent++;
        gap = tx_steady ? 0 : pick_gap();
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reset_pc(logic [31:0] v);
        i_reset_pc_we <= 1'b1;
        i_reset_pc <= v;
        @(posedge i_clk);
        i_reset_pc_we <= 1'b0;
        reset_pc_q = v;
    endtask

    task automatic test_alu_ops();
        send_instr(rtype(FN_NOR, 5'd0, 5'd0, 5'd1, 5'd0));
        send_instr(rtype(FN_SRL, 5'd0, 5'd1, 5'd3, 5'd31));
        send_instr(rtype(FN_SLL, 5'd0, 5'd3, 5'd4, 5'd31));
        send_instr(rtype(FN_SRA, 5'd0, 5'd4, 5'd5, 5'd31));
        send_instr(rtype(FN_SRA, 5'd0, 5'd4, 5'd6, 5'd4));
        send_instr(rtype(FN_SLLV, 5'd4, 5'd1, 5'd7, 5'd0));
        send_instr(rtype(FN_SRLV, 5'd1, 5'd1, 5'd8, 5'd0));
        send_instr(rtype(FN_SRAV, 5'd1, 5'd4, 5'd9, 5'd0));
        send_instr(rtype(FN_ADD, 5'd1, 5'd3, 5'd10, 5'd0));
        send_instr(rtype(FN_SUB, 5'd0, 5'd3, 5'd11, 5'd0));
        send_instr(rtype(FN_ADDU, 5'd4, 5'd4, 5'd12, 5'd0));
        send_instr(rtype(FN_SUBU, 5'd4, 5'd3, 5'd13, 5'd0));
        send_instr(rtype(FN_AND, 5'd1, 5'd6, 5'd14, 5'd0));
        send_instr(rtype(FN_OR, 5'd3, 5'd4, 5'd15, 5'd0));
        send_instr(rtype(FN_XOR, 5'd1, 5'd6, 5'd16, 5'd0));
        send_instr(rtype(FN_SLT, 5'd4, 5'd3, 5'd17, 5'd0));
        send_instr(rtype(FN_SLT, 5'd3, 5'd4, 5'd18, 5'd0));
        send_instr(rtype(FN_ADD, 5'd1, 5'd1, 5'd0, 5'd0));
        send_instr(rtype(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));
        send_instr(rtype(6'h2B, 5'd1, 5'd1, 5'd19, 5'd0));
        send_instr(rtype(6'h09, 5'd1, 5'd0, 5'd31, 5'd0));
        send_instr(32'hFFFF_FFFF);
        send_instr(rtype(FN_JR, 5'd4, 5'd0, 5'd0, 5'd0));
        drain();
    endtask

    task automatic test_hilo_ops();
        send_instr(rtype(FN_MULT, 5'd4, 5'd1, 5'd0, 5'd0));
        send_instr(rtype(FN_MULTU, 5'd1, 5'd1, 5'd0, 5'd0));
        send_instr(rtype(FN_MFHI, 5'd0, 5'd0, 5'd20, 5'd0));
        send_instr(rtype(FN_MFLO, 5'd0, 5'd0, 5'd21, 5'd0));
        send_instr(rtype(FN_MTHI, 5'd6, 5'd0, 5'd0, 5'd0));
        send_instr(rtype(FN_MTLO, 5'd4, 5'd0, 5'd0, 5'd0));
        send_instr(rtype(FN_DIV, 5'd6, 5'd0, 5'd0, 5'd0));
        send_instr(rtype(FN_DIVU, 5'd1, 5'd0, 5'd0, 5'd0));
        send_instr(rtype(FN_DIV, 5'd4, 5'd1, 5'd0, 5'd0));
        send_instr(rtype(FN_DIV, 5'd6, 5'd15, 5'd0, 5'd0));
        send_instr(rtype(FN_DIVU, 5'd1, 5'd15, 5'd0, 5'd0));
        drain();
    endtask

    task automatic test_result_backpressure();
        hold_request = 200;
        tx_steady = 1'b1;
        repeat (20) send_instr(rtype(FN_ADDU, 5'd3, 5'd22, 5'd22, 5'd0));
        tx_steady = 1'b0;
        drain();
    endtask

    task automatic test_random_program(int count);
        logic [31:0] w;
        for (int i = 0; i < count; i++) begin
            w = $urandom();
            if ($urandom_range(9) != 0) w[5:0] = valid_fns[$urandom_range(24)];
            if (w[5:0] == FN_SYSCALL && gpr_read(C_SYS_REG) == C_EXIT_CODE)
                w[5:0] = FN_XOR;
            send_instr(w);
        end
        drain();
    endtask

    task automatic test_exit_syscall();
        send_instr(rtype(FN_NOR, 5'd0, 5'd0, 5'd1, 5'd0));
        send_instr(rtype(FN_SRL, 5'd0, 5'd1, 5'd3, 5'd31));
        send_instr(rtype(FN_SLL, 5'd0, 5'd3, 5'd2, 5'd3));
        send_instr(rtype(FN_SLL, 5'd0, 5'd3, 5'd4, 5'd1));
        send_instr(rtype(FN_ADD, 5'd2, 5'd4, 5'd2, 5'd0));
        send_instr(rtype(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));
        send_instr(rtype(FN_ADDU, 5'd1, 5'd1, 5'd5, 5'd0));
        send_instr(rtype(6'h3F, 5'd0, 5'd0, 5'd0, 5'd0));
        send_instr(rtype(FN_SYSCALL, 5'd0, 5'd0, 5'd0, 5'd0));
        drain();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_reset_pc_we = 1'b0;
        i_reset_pc = '0;
        i_push = 1'b0;
        i_instr_word = '0;
        i_pop = 1'b0;
        for (int i = 0; i < C_NUM_REGS; i++) gpr[i] = '0;
        hi_q = '0;
        lo_q = '0;
        pc_q = C_RESET_PC;
        reset_pc_q = C_RESET_PC;
        stopped_q = 1'b0;
        n_sent = 0;
        n_checked = 0;
        n_errors = 0;
        idle_cycles = 0;
        hold_request = 0;
        hold_left = 0;
        pop_stall = 0;
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_reset_pc(32'd0);
        test_alu_ops();
        test_hilo_ops();
        write_reset_pc(32'hFFFF_FFFF);
        test_result_backpressure();
        test_random_program(300);
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        write_reset_pc($urandom());
        test_random_program(300);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        write_reset_pc(C_RESET_PC);
        test_random_program(600);
        test_exit_syscall();

        $display("Sent %0d instructions and checked %0d results, including multiply, divide,",
                 n_sent, n_checked);
        $display("HI/LO moves, jumps, illegal codes, a long result stall and the exit syscall.");
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("mips_rtype_execute_top_tb: PASS");
        end else begin
            $display("mips_rtype_execute_top_tb: FAIL");
        end
        $finish;
    end

endmodule
